// ----- design/cgs_pkg.sv -----
// Shared constants, codes and command/status types for the conjugate gradient solver.
// No dependencies; compiled first.
package cgs_pkg;

	localparam int FRAC_BITS       = 24;
	localparam int DEF_MAX_N       = 16;
	localparam int DEF_VALUE_WIDTH = 32;

	// fixed field widths of the channels
	localparam int OP_W       = 2;
	localparam int ROW_W      = 4;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int N_USED_W   = 5;
	localparam int LIMIT_W    = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_N_USED = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_SOLVE  = 2'd2
	} item_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_CONVERGED  = 2'd0,
		ST_ITER_LIMIT = 2'd1,
		ST_STAGNATED  = 2'd2,
		ST_ZERO_RHS   = 2'd3
	} solve_status_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLR,
		DP_LDA,
		DP_LDB,
		DP_INIT,
		DP_LIM,
		DP_MATVEC,
		DP_DOT_HG,
		DP_DIV_A,
		DP_UPD,
		DP_DOT_RR,
		DP_DIV_B,
		DP_DIR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   first;
		logic   last;
	} cgs_cmd_t;

	typedef struct packed {
		logic bb_zero;
		logic hg_zero;
		logic rrold_zero;
		logic conv;
		logic div_done;
	} cgs_stat_t;

endpackage

// ----- design/cgs_if.sv -----
// Channel interfaces of the solver: item input, result output, register writes.
// Depends on cgs_pkg.
interface cgs_item_if;
	import cgs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [ROW_W-1:0]     row;
	logic [ROW_W-1:0]     col;
	logic [DATA_W-1:0]    entry_value;
	modport source(output valid, op, row, col, entry_value, input ready);
	modport sink(input valid, op, row, col, entry_value, output ready);
endinterface

interface cgs_result_if;
	import cgs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ROW_W-1:0]     sol_index;
	logic [DATA_W-1:0]    sol_value;
	logic [STATUS_W-1:0]  status;
	logic [N_USED_W-1:0]  iterations;
	logic                 last;
	modport source(output valid, sol_index, sol_value, status, iterations, last, input ready);
	modport sink(input valid, sol_index, sol_value, status, iterations, last, output ready);
endinterface

interface cgs_cfg_if;
	import cgs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- design/cgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- design/cgs_div.sv -----
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated to VW bits.
// One quotient bit per cycle. Depends on cgs_pkg.
module cgs_div #(
	parameter int VW = cgs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   num,
	input  logic signed [63:0]   den,
	output logic                 done,
	output logic signed [VW-1:0] quot
);
	import cgs_pkg::*;

	localparam int STEPS = 64 + FRAC_BITS;
	localparam int CW    = $clog2(STEPS + 1);
	localparam logic [VW:0] LIM  = (VW+1)'(1) << (VW-1);
	localparam logic [VW:0] QMAX = LIM - (VW+1)'(1);

	logic [63:0]   un_q, ud_q, rem_q;
	logic [VW:0]   q_q;
	logic          over_q, neg_q, busy_q, done_q;
	logic [CW-1:0] cnt_q;

	logic [64:0]   rem2;
	logic          ge;
	logic [VW:0]   qn;

	always_comb begin
		rem2 = {rem_q, un_q[63]};
		ge   = rem2 >= {1'b0, ud_q};
		qn   = {q_q[VW-1:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			un_q   <= num[63] ? 64'(-num) : 64'(num);
			ud_q   <= den[63] ? 64'(-den) : 64'(den);
			neg_q  <= num[63] ^ den[63];
			rem_q  <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			un_q  <= {un_q[62:0], 1'b0};
			rem_q <= ge ? 64'(rem2 - {1'b0, ud_q}) : rem2[63:0];
			if (!over_q) begin
				q_q <= qn;
				if (qn > LIM) begin
					over_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			quot = (over_q || q_q >= LIM) ? {1'b1, {(VW-1){1'b0}}} : -$signed(q_q[VW-1:0]);
		end else begin
			quot = (over_q || q_q > QMAX) ? {1'b0, {(VW-1){1'b1}}} : $signed(q_q[VW-1:0]);
		end
	end

	assign done = done_q;
endmodule

// ----- design/cgs_dp.sv -----
// Solver datapath: matrix RAM, vectors, scalar norms, one MAC pipeline and the divider.
// Depends on cgs_pkg, cgs_ram, cgs_div.
module cgs_dp #(
	parameter int MAX_N = cgs_pkg::DEF_MAX_N,
	parameter int VW    = cgs_pkg::DEF_VALUE_WIDTH,
	parameter int IW    = $clog2(MAX_N)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cgs_pkg::cgs_cmd_t             cmd,
	input  logic [IW-1:0]                 i_idx,
	input  logic [IW-1:0]                 j_idx,
	input  logic [cgs_pkg::ROW_W-1:0]     ld_row,
	input  logic [cgs_pkg::ROW_W-1:0]     ld_col,
	input  logic [cgs_pkg::DATA_W-1:0]    ld_value,
	input  logic [cgs_pkg::LIMIT_W-1:0]   limit,
	output cgs_pkg::cgs_stat_t            stat,
	output logic [cgs_pkg::DATA_W-1:0]    x_out
);
	import cgs_pkg::*;

	localparam int DEPTH = MAX_N * MAX_N;
	localparam int AW    = $clog2(DEPTH);
	localparam logic signed [63:0]  VMAX64 = (64'sd1 <<< (VW-1)) - 64'sd1;
	localparam logic signed [63:0]  VMIN64 = -VMAX64 - 64'sd1;
	localparam logic signed [63:0]  S64MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0]  S64MIN = {1'b1, {63{1'b0}}};
	localparam logic signed [127:0] PMAX   = {65'd0, {63{1'b1}}};
	localparam logic signed [63:0]  HALF   = 64'sd1 <<< (FRAC_BITS-1);
	localparam logic signed [VW-1:0] VMAXV = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMINV = {1'b1, {(VW-1){1'b0}}};

	function automatic logic signed [VW-1:0] clamp64(input logic signed [63:0] v);
		if (v > VMAX64) return VMAXV;
		if (v < VMIN64) return VMINV;
		return v[VW-1:0];
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64MIN : S64MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_prod(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		logic signed [2*VW-1:0] p;
		logic signed [127:0]    w;
		p = a * b;
		w = 128'(p);
		if (w > PMAX) return S64MAX;
		if (w < -PMAX) return -S64MAX;
		return w[63:0];
	endfunction

	function automatic logic signed [VW-1:0] rnd64(input logic signed [63:0] v);
		logic signed [63:0] s;
		s = sat_add64(v, HALF);
		return clamp64(s >>> FRAC_BITS);
	endfunction

	function automatic logic signed [VW-1:0] add_clamp(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b, input logic sub);
		logic signed [VW:0] s;
		s = sub ? ({a[VW-1], a} - {b[VW-1], b}) : ({a[VW-1], a} + {b[VW-1], b});
		if (s[VW] != s[VW-1]) return s[VW] ? VMINV : VMAXV;
		return s[VW-1:0];
	endfunction

	// vectors
	logic signed [VW-1:0] b_q [MAX_N];
	logic signed [VW-1:0] x_q [MAX_N];
	logic signed [VW-1:0] r_q [MAX_N];
	logic signed [VW-1:0] g_q [MAX_N];
	logic signed [VW-1:0] h_q [MAX_N];

	// scalars
	logic signed [63:0]   acc_q, hg_q, rr_q, rrold_q, bb_q;
	logic signed [VW-1:0] alpha_q, beta_q;
	logic [63:0]          lim_lo_q, lim_hi_q;
	logic                 div_beta_q;

	// MAC pipeline
	dp_op_t               op_s1, op_s2;
	logic                 first_s1, last_s1, first_s2, last_s2;
	logic [IW-1:0]        i_s1, j_s1, i_s2;
	logic signed [63:0]   p1_s2, p2_s2;

	// matrix store
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic signed [VW-1:0] ram_wdata, a_rd, ld_val;
	logic                 ld_ok;

	always_comb begin
		ld_val    = clamp64(64'($signed(ld_value)));
		ld_ok     = (int'(ld_row) < MAX_N) && (int'(ld_col) < MAX_N);
		ram_raddr = AW'(int'(i_idx) * MAX_N + int'(j_idx));
		ram_we    = (cmd.op == DP_CLR) || (cmd.op == DP_LDA && ld_ok);
		if (cmd.op == DP_LDA) begin
			ram_waddr = AW'(int'(ld_row) * MAX_N + int'(ld_col));
			ram_wdata = ld_val;
		end else begin
			ram_waddr = ram_raddr;
			ram_wdata = '0;
		end
	end

	cgs_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_mat (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (a_rd)
	);

	// divider
	logic                 div_start, div_done;
	logic signed [VW-1:0] div_quot;

	assign div_start = (cmd.op == DP_DIV_A) || (cmd.op == DP_DIV_B);

	cgs_div #(.VW(VW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rr_q),
		.den    ((cmd.op == DP_DIV_B) ? rrold_q : hg_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// multiply stage operands
	logic signed [VW-1:0] ma, mb;
	always_comb begin
		unique case (op_s1)
			DP_INIT:   begin ma = b_q[i_s1];  mb = b_q[i_s1]; end
			DP_MATVEC: begin ma = a_rd;       mb = g_q[j_s1]; end
			DP_DOT_HG: begin ma = h_q[i_s1];  mb = g_q[i_s1]; end
			DP_UPD:    begin ma = alpha_q;    mb = g_q[i_s1]; end
			DP_DOT_RR: begin ma = r_q[i_s1];  mb = r_q[i_s1]; end
			DP_DIR:    begin ma = beta_q;     mb = g_q[i_s1]; end
			default:   begin ma = '0;         mb = '0;        end
		endcase
	end

	logic signed [63:0] sum;
	assign sum = sat_add64(first_s2 ? 64'sd0 : acc_q, p1_s2);

	// control and reset-cleared state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1   <= DP_NOP;
			op_s2   <= DP_NOP;
			bb_q    <= '0;
			rr_q    <= '0;
			rrold_q <= '0;
			for (int k = 0; k < MAX_N; k++) begin
				b_q[k] <= '0;
				x_q[k] <= '0;
			end
		end else begin
			op_s1 <= cmd.op;
			op_s2 <= op_s1;
			if (cmd.op == DP_LDB) begin
				for (int k = 0; k < MAX_N; k++) begin
					if (int'(ld_row) == k) b_q[k] <= ld_val;
				end
			end
			unique case (op_s2)
				DP_INIT: begin
					x_q[i_s2] <= '0;
					if (last_s2) begin
						bb_q <= sum;
						rr_q <= sum;
					end
				end
				DP_UPD: x_q[i_s2] <= add_clamp(x_q[i_s2], rnd64(p1_s2), 1'b0);
				DP_DOT_RR: begin
					if (last_s2) begin
						rrold_q <= rr_q;
						rr_q    <= sum;
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		i_s1     <= i_idx;
		j_s1     <= j_idx;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		i_s2     <= i_s1;
		p1_s2    <= sat_prod(ma, mb);
		p2_s2    <= sat_prod(alpha_q, h_q[i_s1]);
		if (cmd.op == DP_LIM) begin
			lim_lo_q <= limit * bb_q[31:0];
			lim_hi_q <= limit * bb_q[63:32];
		end
		if (div_start) div_beta_q <= (cmd.op == DP_DIV_B);
		if (div_done) begin
			if (div_beta_q) beta_q <= div_quot;
			else alpha_q <= div_quot;
		end
		unique case (op_s2)
			DP_INIT: begin
				acc_q     <= sum;
				r_q[i_s2] <= b_q[i_s2];
				g_q[i_s2] <= b_q[i_s2];
			end
			DP_MATVEC: begin
				acc_q <= sum;
				if (last_s2) h_q[i_s2] <= rnd64(sum);
			end
			DP_DOT_HG: begin
				acc_q <= sum;
				if (last_s2) hg_q <= sum;
			end
			DP_UPD:    r_q[i_s2] <= add_clamp(r_q[i_s2], rnd64(p2_s2), 1'b1);
			DP_DOT_RR: acc_q <= sum;
			DP_DIR:    g_q[i_s2] <= add_clamp(r_q[i_s2], rnd64(p1_s2), 1'b0);
			default: ;
		endcase
	end

	// rr * 2^32 <= limit * bb, both sides 96 bits
	logic [95:0] lim_bb;
	assign lim_bb = {32'd0, lim_lo_q} + {lim_hi_q, 32'd0};

	assign stat.bb_zero    = (bb_q == 64'sd0);
	assign stat.hg_zero    = (hg_q == 64'sd0);
	assign stat.rrold_zero = (rrold_q == 64'sd0);
	assign stat.conv       = ({rr_q, 32'd0} <= lim_bb);
	assign stat.div_done   = div_done;

	assign x_out = DATA_W'(x_q[i_idx]);
endmodule

// ----- design/cgs_ctrl.sv -----
// Solver sequencer: item handshake, config registers, iteration control, result emission.
// Depends on cgs_pkg.
module cgs_ctrl #(
	parameter int MAX_N = cgs_pkg::DEF_MAX_N,
	parameter int IW    = $clog2(MAX_N)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [cgs_pkg::OP_W-1:0]       in_op,
	output logic                           in_ready,
	input  logic                           cfg_valid,
	input  logic [cgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cgs_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           cfg_ready,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [cgs_pkg::ROW_W-1:0]      out_index,
	output logic [cgs_pkg::STATUS_W-1:0]   out_status,
	output logic [cgs_pkg::N_USED_W-1:0]   out_iters,
	output logic                           out_last,
	output cgs_pkg::cgs_cmd_t              cmd,
	output logic [IW-1:0]                  i_idx,
	output logic [IW-1:0]                  j_idx,
	output logic [cgs_pkg::LIMIT_W-1:0]    limit,
	input  cgs_pkg::cgs_stat_t             stat
);
	import cgs_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_INIT, S_LIM, S_CHECK, S_MATVEC, S_HG, S_HGCHK,
		S_DIVA, S_UPD, S_RR, S_RRCHK, S_DIVB, S_DIR, S_DRAIN, S_EMIT
	} state_t;

	state_t              state_q, ret_q;
	logic [IW-1:0]       i_q, j_q;
	logic [IW:0]         k_q, iters_q;
	logic                drain_q;
	solve_status_t       status_q;
	logic [N_USED_W-1:0] n_used_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic [IW:0]   n_eff;
	logic [IW-1:0] last_idx;
	logic          i_last, j_last, in_acc;

	localparam logic [IW-1:0] TOP_IDX = IW'(MAX_N - 1);

	always_comb begin
		if (n_used_q == '0) n_eff = (IW+1)'(1);
		else if (int'(n_used_q) > MAX_N) n_eff = (IW+1)'(MAX_N);
		else n_eff = (IW+1)'(n_used_q);
		last_idx = IW'(n_eff - (IW+1)'(1));
		i_last   = (i_q == last_idx);
		j_last   = (j_q == last_idx);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == S_EMIT);
	assign out_index = ROW_W'(i_q);
	assign out_status = status_q;
	assign out_iters = N_USED_W'(iters_q);
	assign out_last  = i_last;
	assign i_idx     = i_q;
	assign j_idx     = j_q;
	assign limit     = limit_q;

	always_comb begin
		cmd = '{op: DP_NOP, first: 1'b0, last: 1'b0};
		unique case (state_q)
			S_CLEAR: cmd.op = DP_CLR;
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_op)
						OP_LOAD_A: cmd.op = DP_LDA;
						OP_LOAD_B: cmd.op = DP_LDB;
						default: ;
					endcase
				end
			end
			S_INIT:   cmd = '{op: DP_INIT, first: (i_q == '0), last: i_last};
			S_LIM:    if (!stat.bb_zero) cmd.op = DP_LIM;
			S_MATVEC: cmd = '{op: DP_MATVEC, first: (j_q == '0), last: j_last};
			S_HG:     cmd = '{op: DP_DOT_HG, first: (i_q == '0), last: i_last};
			S_HGCHK:  if (!stat.hg_zero) cmd.op = DP_DIV_A;
			S_UPD:    cmd.op = DP_UPD;
			S_RR:     cmd = '{op: DP_DOT_RR, first: (i_q == '0), last: i_last};
			S_RRCHK:  if (!stat.rrold_zero) cmd.op = DP_DIV_B;
			S_DIR:    cmd.op = DP_DIR;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			ret_q    <= S_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			iters_q  <= '0;
			drain_q  <= 1'b0;
			status_q <= ST_CONVERGED;
			n_used_q <= N_USED_W'(16);
			limit_q  <= LIMIT_W'(42950);
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_N_USED: n_used_q <= cfg_data[N_USED_W-1:0];
					CFG_LIMIT:  limit_q  <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					j_q <= j_q + IW'(1);
					if (j_q == TOP_IDX) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
						if (i_q == TOP_IDX) begin
							i_q     <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_acc && in_op == OP_SOLVE) begin
						i_q     <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					i_q <= i_q + IW'(1);
					if (i_last) begin
						ret_q   <= S_LIM;
						state_q <= S_DRAIN;
					end
				end
				S_LIM: begin
					i_q     <= '0;
					iters_q <= '0;
					k_q     <= (IW+1)'(1);
					if (stat.bb_zero) begin
						status_q <= ST_ZERO_RHS;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					i_q <= '0;
					j_q <= '0;
					if (k_q > n_eff) begin
						status_q <= stat.conv ? ST_CONVERGED : ST_ITER_LIMIT;
						state_q  <= S_EMIT;
					end else if (stat.conv) begin
						status_q <= ST_CONVERGED;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_MATVEC;
					end
				end
				S_MATVEC: begin
					j_q <= j_q + IW'(1);
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
						if (i_last) begin
							i_q     <= '0;
							ret_q   <= S_HG;
							state_q <= S_DRAIN;
						end
					end
				end
				S_HG: begin
					i_q <= i_q + IW'(1);
					if (i_last) begin
						ret_q   <= S_HGCHK;
						state_q <= S_DRAIN;
					end
				end
				S_HGCHK: begin
					i_q <= '0;
					if (stat.hg_zero) begin
						status_q <= ST_STAGNATED;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_DIVA;
					end
				end
				S_DIVA: if (stat.div_done) state_q <= S_UPD;
				S_UPD: begin
					i_q     <= i_q + IW'(1);
					iters_q <= k_q;
					if (i_last) begin
						ret_q   <= S_RR;
						state_q <= S_DRAIN;
					end
				end
				S_RR: begin
					i_q <= i_q + IW'(1);
					if (i_last) begin
						ret_q   <= S_RRCHK;
						state_q <= S_DRAIN;
					end
				end
				S_RRCHK: begin
					i_q <= '0;
					if (stat.rrold_zero) begin
						status_q <= ST_STAGNATED;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_DIVB;
					end
				end
				S_DIVB: if (stat.div_done) state_q <= S_DIR;
				S_DIR: begin
					i_q <= i_q + IW'(1);
					if (i_last) begin
						k_q     <= k_q + (IW+1)'(1);
						ret_q   <= S_CHECK;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// idle drain state lets the MAC pipeline write back; left once drain_q is set
					drain_q <= !drain_q;
					i_q     <= '0;
					if (drain_q) state_q <= ret_q;
				end
				S_EMIT: begin
					if (out_ready) begin
						i_q <= i_q + IW'(1);
						if (i_last) begin
							i_q     <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_solve_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_op == OP_SOLVE |=> state_q == S_INIT)
		else $error("solve item did not start initialization");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_DIV_A |-> !stat.hg_zero)
		else $error("alpha division started with zero denominator");

	a_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while results pending");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> i_q <= last_idx)
		else $error("emit index beyond system size");
endmodule

// ----- design/conjugate_gradient_solver.sv -----
// Top level of the conjugate gradient solver: controller plus datapath.
// Depends on cgs_pkg, cgs_if, cgs_ctrl, cgs_dp (with cgs_ram, cgs_div).
//
// Dense conjugate gradient solver in signed Q8.24. Load words (op 0 matrix entry,
// op 1 rhs entry) are taken one per cycle while idle. A solve word runs CG from x=0
// over the leading n x n block (n = n_used, clamped to 1..MAX_N) and then emits n
// result words, index 0 first, each with status and iteration count; input is held
// off until the last result word is taken. One shared MAC pipeline (stages s1 and s2,
// with a second multiplier for alpha*h) runs the init pass, then per iteration the
// MAC passes, drains and checks plus two divisions (radix-2 divider, 64+24 quotient
// steps each), and one more check after the last iteration before the output. After
// reset the matrix is cleared by a pass over all MAX_N*MAX_N entries before the first
// item is accepted; register writes are taken at any time.
module conjugate_gradient_solver #(
	parameter int MAX_N       = cgs_pkg::DEF_MAX_N,
	parameter int VALUE_WIDTH = cgs_pkg::DEF_VALUE_WIDTH
) (
	input logic         clk,
	input logic         arst_n,
	cgs_item_if.sink    items,
	cgs_result_if.source results,
	cgs_cfg_if.sink     cfg
);
	import cgs_pkg::*;

	localparam int IW = $clog2(MAX_N);

	cgs_cmd_t           cmd;
	cgs_stat_t          stat;
	logic [IW-1:0]      i_idx, j_idx;
	logic [LIMIT_W-1:0] limit;

	// sequencer: owns handshakes, config and iteration control
	cgs_ctrl #(.MAX_N(MAX_N), .IW(IW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (items.valid),
		.in_op      (items.op),
		.in_ready   (items.ready),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.cfg_ready  (cfg.ready),
		.out_ready  (results.ready),
		.out_valid  (results.valid),
		.out_index  (results.sol_index),
		.out_status (results.status),
		.out_iters  (results.iterations),
		.out_last   (results.last),
		.cmd        (cmd),
		.i_idx      (i_idx),
		.j_idx      (j_idx),
		.limit      (limit),
		.stat       (stat)
	);

	// datapath: stores, MAC pipeline, divider, stopping test
	cgs_dp #(.MAX_N(MAX_N), .VW(VALUE_WIDTH), .IW(IW)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.i_idx    (i_idx),
		.j_idx    (j_idx),
		.ld_row   (items.row),
		.ld_col   (items.col),
		.ld_value (items.entry_value),
		.limit    (limit),
		.stat     (stat),
		.x_out    (results.sol_value)
	);
endmodule
